>>> rtl/core/dqs_pkg.sv
// Shared types and codes for the double-ended queue with search.
`default_nettype none

package dqs_pkg;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_CONTAINS   = 3'd4;
  localparam logic [2:0] ACT_REMOVE     = 3'd5;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic srch_start;
    logic srch_step;
    logic shift_step;
    logic shift_done;
    logic fetch;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       cnt_zero;
    logic       more;
    logic       cmp_pend;
    logic       sh_pend;
    logic       hit;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/dqs_ctrl.sv
// Controller state machine: sequences execute, search, shift and fetch phases.
`default_nettype none

module dqs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire dqs_pkg::sts_t sts,
  output dqs_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_valid
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_FETCH  = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((sts.action inside {dqs_pkg::ACT_CONTAINS, dqs_pkg::ACT_REMOVE}) &&
            !sts.cnt_zero) begin
          cmd.srch_start = 1'b1;
          state_nxt      = ST_SEARCH;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (sts.hit) begin
          state_nxt = (sts.action == dqs_pkg::ACT_REMOVE) ? ST_SHIFT : ST_FETCH;
        end else if (!sts.more && !sts.cmp_pend) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_SHIFT: begin
        // close the gap one word per cycle, then drop the last entry
        if (!sts.more && !sts.sh_pend) begin
          cmd.shift_done = 1'b1;
          state_nxt      = ST_FETCH;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESP);

endmodule

`default_nettype wire

>>> rtl/core/dqs_datapath.sv
// Datapath: ring store, head and count registers, search compare and result registers.
`default_nettype none

module dqs_datapath #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [2:0]          in_action,
  input  wire logic signed [31:0]  in_value,
  input  wire dqs_pkg::cmd_t       cmd,
  output dqs_pkg::sts_t            sts,
  output logic                     out_found,
  output logic signed [31:0]       out_front_value,
  output logic signed [31:0]       out_back_value,
  output logic [4:0]               out_occupancy,
  output logic                     out_is_empty,
  output logic [1:0]               out_error_code
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  logic [2:0]             act_r, act_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   found_r, found_nxt;
  logic [1:0]             err_r, err_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0]          wr_idx_r, wr_idx_nxt;
  logic                   sh_pend_r, sh_pend_nxt;
  logic [VALUE_WIDTH-1:0] rd0_r, rd1_r;

  logic                   we, re0, re1;
  logic [AW-1:0]          waddr, raddr0, raddr1;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [63:0]            in_ext, front64, back64, cnt64;
  logic                   full, zero, more, hit;
  logic [AW-1:0]          head_m1, head_p1;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign in_ext  = {32'b0, in_value};
  assign full    = (cnt_r == DEPTH_C);
  assign zero    = (cnt_r == '0);
  assign more    = (idx_r < cnt_r);
  assign hit     = cmp_vld_r && (rd0_r == val_r);
  assign head_m1 = (head_r == '0) ? LAST_A : head_r - 1'b1;
  assign head_p1 = (head_r == LAST_A) ? '0 : head_r + 1'b1;

  always_comb begin
    act_nxt     = act_r;
    val_nxt     = val_r;
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    found_nxt   = found_r;
    err_nxt     = err_r;
    idx_nxt     = idx_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    wr_idx_nxt  = wr_idx_r;
    sh_pend_nxt = sh_pend_r;
    we          = 1'b0;
    waddr       = head_r;
    wdata       = val_r;
    re0         = 1'b0;
    raddr0      = head_r;
    re1         = 1'b0;
    raddr1      = head_r;

    if (cmd.load) begin
      act_nxt   = in_action;
      val_nxt   = in_ext[VALUE_WIDTH-1:0];
      found_nxt = 1'b0;
      err_nxt   = dqs_pkg::ERR_OK;
    end

    if (cmd.exec) begin
      case (act_r)
        dqs_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            err_nxt = dqs_pkg::ERR_FULL;
          end else begin
            head_nxt = head_m1;
            we       = 1'b1;
            waddr    = head_m1;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        dqs_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            err_nxt = dqs_pkg::ERR_FULL;
          end else begin
            we      = 1'b1;
            waddr   = slot(head_r, cnt_r);
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        dqs_pkg::ACT_POP_FRONT: begin
          if (zero) begin
            err_nxt = dqs_pkg::ERR_EMPTY;
          end else begin
            head_nxt = head_p1;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end
        dqs_pkg::ACT_POP_BACK: begin
          if (zero) begin
            err_nxt = dqs_pkg::ERR_EMPTY;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.srch_start) begin
      idx_nxt     = '0;
      cmp_vld_nxt = 1'b0;
    end

    if (cmd.srch_step) begin
      // issue one read a cycle, compare the word read the cycle before
      cmp_vld_nxt = 1'b0;
      if (more) begin
        re0         = 1'b1;
        raddr0      = slot(head_r, idx_r);
        idx_nxt     = idx_r + 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = idx_r;
      end
      if (hit) begin
        found_nxt   = 1'b1;
        idx_nxt     = cmp_idx_r + 1'b1;
        sh_pend_nxt = 1'b0;
      end
    end

    if (cmd.shift_step) begin
      sh_pend_nxt = 1'b0;
      if (more) begin
        re0         = 1'b1;
        raddr0      = slot(head_r, idx_r);
        idx_nxt     = idx_r + 1'b1;
        wr_idx_nxt  = idx_r - 1'b1;
        sh_pend_nxt = 1'b1;
      end
      if (sh_pend_r) begin
        we    = 1'b1;
        waddr = slot(head_r, wr_idx_r);
        wdata = rd0_r;
      end
    end

    if (cmd.shift_done) begin
      cnt_nxt = cnt_r - 1'b1;
    end

    if (cmd.fetch) begin
      re0    = 1'b1;
      raddr0 = head_r;
      re1    = !zero;
      raddr1 = slot(head_r, cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
      sh_pend_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      sh_pend_r <= sh_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    val_r     <= val_nxt;
    found_r   <= found_nxt;
    err_r     <= err_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    wr_idx_r  <= wr_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re0) begin
      rd0_r <= mem[raddr0];
    end
    if (re1) begin
      rd1_r <= mem[raddr1];
    end
  end

  always_comb begin
    sts          = '0;
    sts.action   = act_r;
    sts.cnt_zero = zero;
    sts.more     = more;
    sts.cmp_pend = cmp_vld_r;
    sts.sh_pend  = sh_pend_r;
    sts.hit      = hit;
  end

  assign front64 = 64'(rd0_r);
  assign back64  = 64'(rd1_r);
  assign cnt64   = 64'(cnt_r);

  assign out_found       = found_r;
  assign out_front_value = zero ? '0 : front64[31:0];
  assign out_back_value  = zero ? '0 : back64[31:0];
  assign out_occupancy   = cnt64[4:0];
  assign out_is_empty    = zero;
  assign out_error_code  = err_r;

endmodule

`default_nettype wire

>>> rtl/core/double_ended_queue_with_search.sv
// Top level of the double-ended queue with front search and remove.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------------
//   input   | in_action, in_value                     | start high, busy low
//   result  | out_found .. out_error_code             | out_valid, one cycle
//
// A push, pop, spare action or empty search passes, after accept, through execute, fetch
// front/back and respond. Contains reads one entry a cycle and compares each entry once its
// read is registered. Remove searches the same way, then moves each entry behind the match
// one place forward. busy drops as out_valid does, and the next word may then be accepted.
// Reset empties the queue at once; the store itself is not cleared.
// The receiver cannot stall: each word is on the out_ ports for one cycle.
`default_nettype none

module double_ended_queue_with_search #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_action,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  output logic                    out_found,
  output logic signed [31:0]      out_front_value,
  output logic signed [31:0]      out_back_value,
  output logic [4:0]              out_occupancy,
  output logic                    out_is_empty,
  output logic [1:0]              out_error_code
);

  dqs_pkg::cmd_t cmd;
  dqs_pkg::sts_t sts;

  dqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  dqs_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_found       (out_found),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_occupancy   (out_occupancy),
    .out_is_empty    (out_is_empty),
    .out_error_code  (out_error_code)
  );

endmodule

`default_nettype wire

>>> sim/double_ended_queue_with_search_test.sv
// Testbench for the double-ended queue with front search and remove.
`default_nettype none

module double_ended_queue_with_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dqs_pkg::*;

  // Spare action codes: the block reports the queue unchanged
  localparam logic [2:0] ACT_RESERVED_LO = 3'd6;
  localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

  localparam int RANDOM_WORDS = 650;
  localparam int SEGMENT_LEN  = 40;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_SEARCH, MIX_EVEN} mix_e;

  typedef struct packed {
    logic        found;
    logic [31:0] front;
    logic [31:0] back;
    logic [4:0]  occupancy;
    logic        is_empty;
    logic [1:0]  err;
  } deque_status_t;

  class deque_tracker;
    localparam int QUEUE_DEPTH = 16;

    logic [31:0]   contents[$];
    deque_status_t pending[$];
    int unsigned   failures;

    function void note_request(logic [2:0] action, logic [31:0] value);
      deque_status_t s;
      int hit_at;
      s = '0;
      hit_at = -1;
      for (int i = 0; i < contents.size(); i++) begin
        if (hit_at < 0 && contents[i] == value) hit_at = i;
      end
      case (action)
        ACT_PUSH_FRONT: begin
          if (contents.size() >= QUEUE_DEPTH) s.err = ERR_FULL;
          else contents.push_front(value);
        end
        ACT_PUSH_BACK: begin
          if (contents.size() >= QUEUE_DEPTH) s.err = ERR_FULL;
          else contents.push_back(value);
        end
        ACT_POP_FRONT: begin
          if (contents.size() == 0) s.err = ERR_EMPTY;
          else void'(contents.pop_front());
        end
        ACT_POP_BACK: begin
          if (contents.size() == 0) s.err = ERR_EMPTY;
          else void'(contents.pop_back());
        end
        ACT_CONTAINS: s.found = (hit_at >= 0);
        ACT_REMOVE: begin
          if (hit_at >= 0) begin
            s.found = 1'b1;
            contents.delete(hit_at);
          end
        end
        default: ;
      endcase
      s.occupancy = 5'(contents.size());
      s.is_empty  = (contents.size() == 0);
      if (contents.size() != 0) begin
        s.front = contents[0];
        s.back  = contents[contents.size() - 1];
      end
      pending.push_back(s);
    endfunction

    function void check_status(deque_status_t got);
      deque_status_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] result word with nothing outstanding: occ=%0d", $realtime,
                   got.occupancy);
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found || got.front !== want.front ||
          got.back !== want.back || got.occupancy !== want.occupancy ||
          got.is_empty !== want.is_empty || got.err !== want.err) begin
        failures++;
        if (failures <= 10) begin
          $display("[%0t] mismatch: expected found=%0b front=%0d back=%0d occ=%0d empty=%0b err=%0d",
                   $realtime, want.found, $signed(want.front), $signed(want.back),
                   want.occupancy, want.is_empty, want.err);
          $display("[%0t]           actual   found=%0b front=%0d back=%0d occ=%0d empty=%0b err=%0d",
                   $realtime, got.found, $signed(got.front), $signed(got.back),
                   got.occupancy, got.is_empty, got.err);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_action = ACT_PUSH_FRONT;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_found;
  logic signed [31:0] out_front_value;
  logic signed [31:0] out_back_value;
  logic [4:0]         out_occupancy;
  logic               out_is_empty;
  logic [1:0]         out_error_code;

  deque_tracker tracker = new;
  int unsigned  cycle_count = 0;

  double_ended_queue_with_search dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_occupancy   (out_occupancy),
    .out_is_empty    (out_is_empty),
    .out_error_code  (out_error_code)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("double_ended_queue_with_search test failed");
      $finish;
    end
  end

  // A result word always belongs to an older request, so check before noting
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        tracker.check_status({out_found, out_front_value, out_back_value, out_occupancy,
                              out_is_empty, out_error_code});
      if (start && !busy) tracker.note_request(in_action, in_value);
    end
  end

  task automatic send_word(input logic [2:0] action, input logic [31:0] value);
    @(negedge clk);
    start     = 1'b1;
    in_action = action;
    in_value  = value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(input int cycles);
    @(negedge clk);
    start     = 1'b0;
    in_action = 3'($urandom);
    in_value  = $urandom;
    // Hold back only over cycles in which the block could take a word
    while (busy) @(negedge clk);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] any_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(8)) - 4);
      2: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Aim most searches at values actually held, so removes shift entries
  function automatic logic [31:0] search_value();
    if (tracker.contents.size() != 0 && $urandom_range(99) < 60)
      return tracker.contents[$urandom_range(tracker.contents.size() - 1)];
    return any_value();
  endfunction

  function automatic logic [2:0] choose_action(mix_e mix);
    int r;
    int push_lim;
    int pop_lim;
    int look_lim;
    r = $urandom_range(99);
    if (r < 3) return r[0] ? ACT_RESERVED_HI : ACT_RESERVED_LO;
    case (mix)
      MIX_FILL:   begin push_lim = 62; pop_lim = 74; look_lim = 88; end
      MIX_DRAIN:  begin push_lim = 20; pop_lim = 68; look_lim = 84; end
      MIX_SEARCH: begin push_lim = 30; pop_lim = 45; look_lim = 75; end
      default:    begin push_lim = 35; pop_lim = 66; look_lim = 83; end
    endcase
    if (r < push_lim) return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    if (r < pop_lim) return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    if (r < look_lim) return ACT_CONTAINS;
    return ACT_REMOVE;
  endfunction

  initial begin
    mix_e       mix;
    logic [2:0] action;
    logic [31:0] value;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty queue: refused pops, searches that miss, spare codes
    send_word(ACT_POP_FRONT, 32'h1234_5678);
    send_word(ACT_POP_BACK, 32'h0);
    send_word(ACT_CONTAINS, 32'h0);
    send_word(ACT_REMOVE, 32'h0);
    send_word(ACT_RESERVED_LO, 32'h5);
    send_word(ACT_RESERVED_HI, 32'hFFFF_FFFF);

    // Fill from both ends with extremes and duplicates
    for (int i = 0; i < 16; i++) begin
      case (i)
        0: value = 32'h7FFF_FFFF;
        1: value = 32'h8000_0000;
        2: value = 32'hFFFF_FFFF;
        default: value = 32'(i % 3);
      endcase
      send_word(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, value);
    end
    send_word(ACT_PUSH_FRONT, 32'h4);
    send_word(ACT_PUSH_BACK, 32'h4);
    send_word(ACT_REMOVE, 32'h1);
    send_word(ACT_CONTAINS, 32'h8000_0000);
    wait_drained();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % SEGMENT_LEN == 0) mix = mix_e'($urandom_range(3));
      if (n % 200 == 199) wait_drained();
      // Hold the sender back now and then, except across one long burst
      if ((n < 250 || n >= 400) && $urandom_range(99) < 23) idle_for($urandom_range(1, 2));
      action = choose_action(mix);
      if (action == ACT_CONTAINS || action == ACT_REMOVE) value = search_value();
      else value = any_value();
      send_word(action, value);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.pending.size() != 0)
      $display("%0d result words never arrived", tracker.pending.size());
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("double_ended_queue_with_search test passed");
    end else begin
      $display("double_ended_queue_with_search test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
